### rtl/nlr_pkg.sv
package nlr_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [CH_W-1:0]     char_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ACCEPT = 2'd0;
  localparam status_t ST_REJECT = 2'd1;
  localparam status_t ST_LONG   = 2'd2;

  localparam logic REG_SCALAR_MODE = 1'b0;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_POINT = 8'h2E;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_UE    = 8'h45;
  localparam char_t CH_LE    = 8'h65;

  typedef struct packed {
    logic  valid;
    char_t ch;
    logic  start_req;
  } in_stage_t;

endpackage

### rtl/nlr_if.sv
interface nlr_in_if;
  logic               valid;
  logic               ready;
  nlr_pkg::char_t     ch;
  logic               start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface nlr_out_if;
  logic               valid;
  logic               ready;
  nlr_pkg::status_t   status;
  nlr_pkg::len_t      length;

  modport source (output valid, output status, output length, input ready);
  modport sink   (input valid, input status, input length, output ready);
endinterface

### rtl/nlr_cfg.sv
module nlr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nlr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nlr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nlr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           scalar_mode
);
  import nlr_pkg::*;

  logic scalar_mode_r;
  logic reg_sel;

  assign reg_sel     = (paddr[CFG_ADDR_W-1] == REG_SCALAR_MODE);
  assign pready      = 1'b1;
  assign scalar_mode = scalar_mode_r;
  assign prdata      = reg_sel ? {{(CFG_DATA_W-1){1'b0}}, scalar_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scalar_mode_r <= 1'b1;
    end else if (psel && penable && pwrite && reg_sel) begin
      scalar_mode_r <= pwdata[0];
    end
  end

endmodule

### rtl/nlr_in_stage.sv
module nlr_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  nlr_in_if.sink             in_chan,
  input  logic               advance,
  output nlr_pkg::in_stage_t stage
);
  import nlr_pkg::*;

  in_stage_t stage_r;
  logic      load;

  assign in_chan.ready = !stage_r.valid || advance;
  assign load          = in_chan.valid && in_chan.ready;
  assign stage         = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (in_chan.ready) begin
      stage_r.valid <= in_chan.valid;
    end
    if (load) begin
      stage_r.ch        <= in_chan.ch;
      stage_r.start_req <= in_chan.start_req;
    end
  end

endmodule

### rtl/nlr_scan.sv
module nlr_scan #(
  parameter logic [7:0] LEN_LIMIT = 8'd255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nlr_pkg::in_stage_t stage,
  input  logic               scalar_mode,
  output logic               advance,
  nlr_out_if.source          out_chan
);
  import nlr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LEAD, PH_SIGN, PH_INT, PH_FRAC, PH_EXP, PH_EXPSGN, PH_EXPDIG
  } phase_t;

  phase_t  phase_r, phase_nxt, ph, tgt;
  len_t    consumed_r, consumed_nxt, cons;
  logic    had_int_r, had_int_nxt, hi;
  logic    had_frac_r, had_frac_nxt, hf;
  logic    out_valid_r;
  status_t status_r, status_nxt;
  len_t    length_r, length_nxt;
  logic    emit;
  logic    take, fin_acc, is_dig, is_sp, is_e;
  char_t   c;

  assign c      = stage.ch;
  assign is_dig = (c >= CH_0) && (c <= CH_9);
  assign is_sp  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  assign is_e   = (c == CH_LE) || (c == CH_UE);

  assign advance         = stage.valid && (!out_valid_r || out_chan.ready);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = status_r;
  assign out_chan.length = length_r;

  always_comb begin
    ph   = stage.start_req ? PH_LEAD : phase_r;
    cons = stage.start_req ? '0 : consumed_r;
    hi   = stage.start_req ? 1'b0 : had_int_r;
    hf   = stage.start_req ? 1'b0 : had_frac_r;

    take    = 1'b0;
    fin_acc = 1'b0;
    tgt     = PH_IDLE;
    unique case (ph)
      PH_LEAD: begin
        if (is_sp) begin
          take = 1'b1; tgt = PH_LEAD;
        end else if (c == CH_MINUS) begin
          take = 1'b1; tgt = PH_SIGN;
        end else if (is_dig) begin
          take = 1'b1; tgt = PH_INT;
        end else if (scalar_mode && c == CH_POINT) begin
          take = 1'b1; tgt = PH_FRAC;
        end
      end
      PH_SIGN: begin
        if (is_dig) begin
          take = 1'b1; tgt = PH_INT;
        end else if (scalar_mode && c == CH_POINT) begin
          take = 1'b1; tgt = PH_FRAC;
        end
      end
      PH_INT: begin
        if (is_dig) begin
          take = 1'b1; tgt = PH_INT;
        end else if (scalar_mode && c == CH_POINT) begin
          take = 1'b1; tgt = PH_FRAC;
        end else if (scalar_mode && is_e) begin
          take = 1'b1; tgt = PH_EXP;
        end else begin
          fin_acc = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          take = 1'b1; tgt = PH_FRAC;
        end else if (!hi && !hf) begin
          take = 1'b0;
        end else if (is_e) begin
          take = 1'b1; tgt = PH_EXP;
        end else begin
          fin_acc = 1'b1;
        end
      end
      PH_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          take = 1'b1; tgt = PH_EXPSGN;
        end else if (is_dig) begin
          take = 1'b1; tgt = PH_EXPDIG;
        end
      end
      PH_EXPSGN: begin
        if (is_dig) begin
          take = 1'b1; tgt = PH_EXPDIG;
        end
      end
      PH_EXPDIG: begin
        if (is_dig) begin
          take = 1'b1; tgt = PH_EXPDIG;
        end else begin
          fin_acc = 1'b1;
        end
      end
      default: begin
        take = 1'b0;
      end
    endcase

    phase_nxt    = ph;
    consumed_nxt = cons;
    had_int_nxt  = hi;
    had_frac_nxt = hf;
    emit         = 1'b0;
    status_nxt   = ST_ACCEPT;
    length_nxt   = cons;
    if (ph != PH_IDLE) begin
      if (fin_acc) begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
      end else if (!take) begin
        emit       = 1'b1;
        status_nxt = ST_REJECT;
        length_nxt = '0;
        phase_nxt  = PH_IDLE;
      end else if (cons >= LEN_LIMIT) begin
        emit       = 1'b1;
        status_nxt = ST_LONG;
        length_nxt = LEN_LIMIT;
        phase_nxt  = PH_IDLE;
      end else begin
        consumed_nxt = cons + 8'd1;
        phase_nxt    = tgt;
        if (is_dig && ph == PH_FRAC) begin
          had_frac_nxt = 1'b1;
        end else if (is_dig && (ph == PH_LEAD || ph == PH_SIGN || ph == PH_INT)) begin
          had_int_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      consumed_r  <= '0;
      had_int_r   <= 1'b0;
      had_frac_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r    <= phase_nxt;
        consumed_r <= consumed_nxt;
        had_int_r  <= had_int_nxt;
        had_frac_r <= had_frac_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance && emit) begin
      status_r <= status_nxt;
      length_r <= length_nxt;
    end
  end

endmodule

### rtl/numeric_literal_recognizer_unit.sv
// Channel   Direction  Payload              Handshake
// in_chan   sink       ch[7:0], start_req   valid/ready
// out_chan  source     status[1:0], len[7:0] valid/ready
// cfg (APB) slave      scalar_mode @ 0x0    psel/penable, pready tied high
//
// One character is accepted per cycle while in_chan.ready is high; the result it decides is registered.
// The path is an input register, one state transition step and a result register.
// Reset is synchronous and active low; it clears the scan state and both valid flags.
// A stalled result holds the input register, so in_chan.ready drops only while both are full.
module numeric_literal_recognizer_unit #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nlr_in_if.sink                         in_chan,
  nlr_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nlr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nlr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nlr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import nlr_pkg::*;

  localparam logic [7:0] LEN_LIMIT = (MAX_LEN < 255) ? 8'(MAX_LEN) : 8'd255;

  logic      scalar_mode;
  logic      advance;
  in_stage_t stage;

  nlr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .scalar_mode (scalar_mode)
  );

  nlr_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .stage   (stage)
  );

  nlr_scan #(
    .LEN_LIMIT (LEN_LIMIT)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .scalar_mode (scalar_mode),
    .advance     (advance),
    .out_chan    (out_chan)
  );

endmodule
